// ===== rtl/doa_pkg.sv =====
package doa_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam int PHASE_W = 15;
    localparam int DIFF_W = 17;
    localparam int COEF_W = 18;
    localparam int PROD_W = 35;
    localparam int SUM_W = 37;
    localparam int MAG_W = 33;
    localparam int NORM_W = 30;
    localparam int SQ_W = 60;
    localparam int RAD_W = 61;
    localparam int ROOT_W = 63;
    localparam int RHO_W = 31;
    localparam int CORD_W = 34;
    localparam int ANG_W = 34;
    localparam int ATAN_W = 30;
    localparam int BIN_W = 16;
    localparam int BW_W = 32;
    localparam int FPROD_W = 48;
    localparam int FREQ_W = 24;
    localparam int HEAD_W = 15;
    localparam int ELEV_W = 14;

    localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam int ANG_LIMIT = 12868;

    localparam logic signed [COEF_W-1:0] CAL [9] = '{
        18'sd19327,  -18'sd28694,  18'sd9367,
        -18'sd335,   -18'sd16569,  18'sd16904,
        -18'sd60078, 18'sd56130,   -18'sd60051
    };

    typedef struct packed {
        logic [2:0] neg;
        logic [MAG_W-1:0] mag0;
        logic [MAG_W-1:0] mag1;
        logic [MAG_W-1:0] mag2;
        logic valid;
        logic [FREQ_W-1:0] freq;
    } vec_item_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [ELEV_W-1:0] elevation;
        logic [FREQ_W-1:0] freq;
        logic valid;
    } result_t;

    typedef struct packed {
        logic start;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] x;
    } cordic_req_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0: r = 30'h3243F6A8;
            5'd1: r = 30'h1DAC6705;
            5'd2: r = 30'h0FADBAFC;
            5'd3: r = 30'h07F56EA6;
            5'd4: r = 30'h03FEAB76;
            5'd5: r = 30'h01FFD55B;
            5'd6: r = 30'h00FFFAAA;
            5'd7: r = 30'h007FFF55;
            5'd8: r = 30'h003FFFEA;
            5'd9: r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            5'd30: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/doa_fifo.sv =====
module doa_fifo
    import doa_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = MID_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/doa_front.sv =====
module doa_front
    import doa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [PHASE_W-1:0] phase_reference,
    input  logic signed [PHASE_W-1:0] phase_first,
    input  logic signed [PHASE_W-1:0] phase_second,
    input  logic signed [PHASE_W-1:0] phase_third,
    input  logic [BIN_W-1:0]          bin_index,
    input  logic [BW_W-1:0]           bin_width,
    output logic                      out_valid,
    output vec_item_t                 out_item,
    input  logic                      out_ready
);

    logic                      advance;
    logic                      s1_valid_reg;
    logic signed [DIFF_W-1:0]  s1_d_reg [3];
    logic [FPROD_W-1:0]        s1_prod_reg;
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  s2_p_reg [9];
    logic [FREQ_W-1:0]         s2_freq_reg;
    logic                      s3_valid_reg;
    vec_item_t                 s3_item_reg;
    logic signed [DIFF_W-1:0]  d_in [3];
    logic [FPROD_W-FREQ_W+8:0] freq_round;
    logic signed [SUM_W-1:0]   m_sum [3];
    logic signed [SUM_W-1:0]   m_abs [3];
    vec_item_t                 item_next;

    assign advance = !s3_valid_reg || out_ready;
    assign full = !advance;
    assign out_valid = s3_valid_reg;
    assign out_item = s3_item_reg;

    always_comb
    begin
        d_in[0] = DIFF_W'(phase_first) - DIFF_W'(phase_reference);
        d_in[1] = DIFF_W'(phase_second) - DIFF_W'(phase_reference);
        d_in[2] = DIFF_W'(phase_third) - DIFF_W'(phase_reference);
    end

    assign freq_round = (FPROD_W-FREQ_W+9)'((49'(s1_prod_reg) + 49'h8000) >> 16);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            m_sum[r] = SUM_W'(s2_p_reg[r*3]) + SUM_W'(s2_p_reg[r*3+1])
                + SUM_W'(s2_p_reg[r*3+2]);
            m_abs[r] = (m_sum[r] < 0) ? -m_sum[r] : m_sum[r];
        end
        item_next.neg = {m_sum[2] < 0, m_sum[1] < 0, m_sum[0] < 0};
        item_next.mag0 = m_abs[0][MAG_W-1:0];
        item_next.mag1 = m_abs[1][MAG_W-1:0];
        item_next.mag2 = m_abs[2][MAG_W-1:0];
        item_next.valid = (m_sum[0] != 0) || (m_sum[1] != 0) || (m_sum[2] != 0);
        item_next.freq = s2_freq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i] <= d_in[i];
            end
            s1_prod_reg <= FPROD_W'(bin_index) * FPROD_W'(bin_width);
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_p_reg[r*3+c] <= PROD_W'(s1_d_reg[c]) * PROD_W'(CAL[r*3+c]);
                end
            end
            s2_freq_reg <= (freq_round > (FPROD_W-FREQ_W+9)'({FREQ_W{1'b1}}))
                ? {FREQ_W{1'b1}} : freq_round[FREQ_W-1:0];
            s3_item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

endmodule

// ===== rtl/doa_cordic.sv =====
module doa_cordic
    import doa_pkg::*;
#(
    parameter int ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cordic_req_t              req,
    output logic                     done,
    output logic signed [ANG_W-1:0]  angle
);

    localparam int ITER_W = $clog2(ITERATIONS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [ANG_W-1:0]  step;

    assign done = done_reg;
    assign angle = ang_reg;
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign step = {{(ANG_W-ATAN_W){1'b0}}, atan_entry(5'(iter_reg))};

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            if (req.y == 0)
            begin
                ang_reg <= (req.x < 0) ? ANG_PI : '0;
            end
            else if (req.x < 0)
            begin
                if (req.y > 0)
                begin
                    x_reg <= req.y;
                    y_reg <= -req.x;
                    ang_reg <= ANG_HALF_PI;
                end
                else
                begin
                    x_reg <= -req.y;
                    y_reg <= req.x;
                    ang_reg <= -ANG_HALF_PI;
                end
            end
            else
            begin
                x_reg <= req.x;
                y_reg <= req.y;
                ang_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                ang_reg <= ang_reg + step;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                ang_reg <= ang_reg - step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                iter_reg <= '0;
                if (req.y == 0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (iter_reg == ITER_W'(ITERATIONS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/doa_back.sv =====
module doa_back
    import doa_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_empty,
    output logic      in_pop,
    input  vec_item_t in_item,
    input  logic      out_full,
    output logic      out_push,
    output result_t   out_item
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQ0 = 4'd2;
    localparam logic [3:0] S_SQ1 = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_HSTART = 4'd5;
    localparam logic [3:0] S_HWAIT = 4'd6;
    localparam logic [3:0] S_ESTART = 4'd7;
    localparam logic [3:0] S_EWAIT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic signed [ANG_W:0] LIM_HI = (ANG_W+1)'(ANG_LIMIT);
    localparam logic signed [ANG_W:0] LIM_LO = -(ANG_W+1)'(ANG_LIMIT);

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic [MAG_W-1:0]         mag_reg [3];
    logic [MAG_W-1:0]         mag_next [3];
    logic [2:0]               neg_reg;
    logic [2:0]               neg_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic [FREQ_W-1:0]        freq_reg;
    logic [FREQ_W-1:0]        freq_next;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_next;
    logic [RAD_W-1:0]         v_reg;
    logic [RAD_W-1:0]         v_next;
    logic [ROOT_W-1:0]        res_reg;
    logic [ROOT_W-1:0]        res_next;
    logic [4:0]               k_reg;
    logic [4:0]               k_next;
    logic signed [HEAD_W-1:0] heading_reg;
    logic signed [HEAD_W-1:0] heading_next;
    logic [ELEV_W-1:0]        elev_reg;
    logic [ELEV_W-1:0]        elev_next;

    logic [MAG_W-1:0]         mx;
    logic [ROOT_W-1:0]        sqrt_bit;
    logic [ROOT_W-1:0]        sqrt_trial;
    logic                     sqrt_take;
    logic signed [CORD_W-1:0] mz [3];
    logic signed [CORD_W-1:0] ms [3];
    logic signed [ANG_W:0]    q12;
    cordic_req_t              creq;
    logic                     cdone;
    logic signed [ANG_W-1:0]  cangle;

    doa_cordic #(
        .ITERATIONS(ANGLE_ITERATIONS)
    ) u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .req(creq),
        .done(cdone),
        .angle(cangle)
    );

    assign in_pop = (state_reg == S_IDLE) && !in_empty;
    assign out_push = (state_reg == S_DONE) && !out_full;
    assign out_item.heading = heading_reg;
    assign out_item.elevation = elev_reg;
    assign out_item.freq = freq_reg;
    assign out_item.valid = valid_reg;

    assign sqrt_bit = ROOT_W'(1) << (6'd62 - {k_reg, 1'b0});
    assign sqrt_trial = res_reg + sqrt_bit;
    assign sqrt_take = (ROOT_W'(v_reg) >= sqrt_trial);
    assign q12 = ((ANG_W+1)'(cangle) + (ANG_W+1)'(131072)) >>> 18;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            mz[i] = {{(CORD_W-NORM_W){1'b0}}, mag_reg[i][NORM_W-1:0]};
            ms[i] = neg_reg[i] ? -mz[i] : mz[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = mag_reg[i];
        end
        neg_next = neg_reg;
        valid_next = valid_reg;
        freq_next = freq_reg;
        sq_next = sq_reg;
        v_next = v_reg;
        res_next = res_reg;
        k_next = k_reg;
        heading_next = heading_reg;
        elev_next = elev_reg;
        creq.start = 1'b0;
        creq.y = ms[1];
        creq.x = ms[0];
        case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    mag_next[0] = in_item.mag0;
                    mag_next[1] = in_item.mag1;
                    mag_next[2] = in_item.mag2;
                    neg_next = in_item.neg;
                    valid_next = in_item.valid;
                    freq_next = in_item.freq;
                    heading_next = '0;
                    elev_next = '0;
                    state_next = in_item.valid ? S_NORM : S_DONE;
                end
            end
            S_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mx >= MAG_W'(64'd1 << 31))
                    begin
                        mag_next[i] = mag_reg[i] >> 2;
                    end
                    else if (mx >= MAG_W'(64'd1 << 30))
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                    else if (mx < MAG_W'(64'd1 << 13))
                    begin
                        mag_next[i] = mag_reg[i] << 16;
                    end
                    else if (mx < MAG_W'(64'd1 << 21))
                    begin
                        mag_next[i] = mag_reg[i] << 8;
                    end
                    else if (mx < MAG_W'(64'd1 << 25))
                    begin
                        mag_next[i] = mag_reg[i] << 4;
                    end
                    else if (mx < MAG_W'(64'd1 << 27))
                    begin
                        mag_next[i] = mag_reg[i] << 2;
                    end
                    else if (mx < MAG_W'(64'd1 << 29))
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                if ((mx >= MAG_W'(64'd1 << 29)) && (mx < MAG_W'(64'd1 << 30)))
                begin
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                sq_next = SQ_W'(mag_reg[0][NORM_W-1:0]) * SQ_W'(mag_reg[0][NORM_W-1:0]);
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                v_next = RAD_W'(sq_reg)
                    + RAD_W'(SQ_W'(mag_reg[1][NORM_W-1:0]) * SQ_W'(mag_reg[1][NORM_W-1:0]));
                res_next = '0;
                k_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sqrt_take)
                begin
                    v_next = v_reg - sqrt_trial[RAD_W-1:0];
                    res_next = (res_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 5'd31)
                begin
                    state_next = S_HSTART;
                end
            end
            S_HSTART:
            begin
                creq.start = 1'b1;
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (cdone)
                begin
                    if (q12 < LIM_LO)
                    begin
                        heading_next = HEAD_W'(LIM_LO);
                    end
                    else if (q12 > LIM_HI)
                    begin
                        heading_next = HEAD_W'(LIM_HI);
                    end
                    else
                    begin
                        heading_next = q12[HEAD_W-1:0];
                    end
                    state_next = S_ESTART;
                end
            end
            S_ESTART:
            begin
                creq.start = 1'b1;
                creq.y = {{(CORD_W-RHO_W){1'b0}}, res_reg[RHO_W-1:0]};
                creq.x = ms[2];
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (cdone)
                begin
                    if (q12 < 0)
                    begin
                        elev_next = '0;
                    end
                    else if (q12 > LIM_HI)
                    begin
                        elev_next = ELEV_W'(LIM_HI);
                    end
                    else
                    begin
                        elev_next = q12[ELEV_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i] <= mag_next[i];
        end
        neg_reg <= neg_next;
        valid_reg <= valid_next;
        freq_reg <= freq_next;
        sq_reg <= sq_next;
        v_reg <= v_next;
        res_reg <= res_next;
        k_reg <= k_next;
        heading_reg <= heading_next;
        elev_reg <= elev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/hydrophone_direction_of_arrival_top.sv =====
// Direction of arrival and tone frequency from four hydrophone phases.
// Input queue side: an item (four Q3.12 phases and an FFT bin index) is taken
// at a clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest result is on heading,
// elevation, frequency_hz and direction_valid; pop takes it.
// Configuration: the bin width is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Writes are to be made while idle;
// the block itself does not enforce this.
// A three-stage front pipeline forms the direction vector and the frequency
// and feeds a four-entry queue; the back end normalizes the vector, takes a
// 32-step square root and runs one shared CORDIC twice, one item at a time.
// A zero vector goes straight to the result; an atan2 with a zero y operand
// skips the CORDIC iterations.
// When the receiver stalls, two results are held, then the back end waits,
// then the middle queue fills and finally full is raised.
// Reset empties all queues and clears the bin width to zero.
module hydrophone_direction_of_arrival_top
    import doa_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [PHASE_W-1:0] phase_reference,
    input  logic signed [PHASE_W-1:0] phase_first,
    input  logic signed [PHASE_W-1:0] phase_second,
    input  logic signed [PHASE_W-1:0] phase_third,
    input  logic [BIN_W-1:0]          bin_index,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [HEAD_W-1:0]  heading,
    output logic [ELEV_W-1:0]         elevation,
    output logic [FREQ_W-1:0]         frequency_hz,
    output logic                      direction_valid,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [BW_W-1:0]           cfg_data
);

    localparam int VEC_W = $bits(vec_item_t);
    localparam int RES_W = $bits(result_t);

    logic [BW_W-1:0] bin_width_reg;
    logic            front_valid;
    vec_item_t       front_item;
    logic            mid_full;
    logic            mid_empty;
    logic            mid_pop;
    logic [VEC_W-1:0] mid_data;
    logic            out_full;
    logic            out_push;
    result_t         back_item;
    logic [RES_W-1:0] out_data;
    result_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bin_width_reg <= cfg_data;
        end
    end

    doa_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .phase_reference(phase_reference),
        .phase_first(phase_first),
        .phase_second(phase_second),
        .phase_third(phase_third),
        .bin_index(bin_index),
        .bin_width(bin_width_reg),
        .out_valid(front_valid),
        .out_item(front_item),
        .out_ready(!mid_full)
    );

    doa_fifo #(
        .WIDTH(VEC_W),
        .DEPTH(MID_DEPTH)
    ) u_mid_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(front_valid),
        .wr_data(front_item),
        .full(mid_full),
        .pop(mid_pop),
        .rd_data(mid_data),
        .empty(mid_empty)
    );

    doa_back #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_empty(mid_empty),
        .in_pop(mid_pop),
        .in_item(vec_item_t'(mid_data)),
        .out_full(out_full),
        .out_push(out_push),
        .out_item(back_item)
    );

    doa_fifo #(
        .WIDTH(RES_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(out_push),
        .wr_data(back_item),
        .full(out_full),
        .pop(pop),
        .rd_data(out_data),
        .empty(empty)
    );

    assign res = result_t'(out_data);
    assign heading = res.heading;
    assign elevation = res.elevation;
    assign frequency_hz = res.freq;
    assign direction_valid = res.valid;

endmodule

// ===== rtl/doa_checker.sv =====
module doa_checker
    import doa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic signed [HEAD_W-1:0]  heading,
    input logic [ELEV_W-1:0]         elevation,
    input logic                      direction_valid
);

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (heading <= 15'sd12868) && (heading >= -15'sd12868))
        else $error("Heading is outside its range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (elevation <= 14'd12868))
        else $error("Elevation is outside its range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !direction_valid) |-> (heading == '0) && (elevation == '0))
        else $error("Angles are nonzero for a zero direction vector.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(heading) && $stable(elevation))
        else $error("A waiting result transaction changed or vanished.");

endmodule

bind hydrophone_direction_of_arrival_top doa_checker u_doa_checker (.*);
